@@ design/bsa_pkg.sv @@
// Shared types and codes for the banker's safety allocator.
// Used by bsa_lane, bsa_merge and bankers_safety_allocator_top; no dependencies.
package bsa_pkg;

  localparam int unsigned DEF_PROCESSES    = 8;
  localparam int unsigned DEF_RESOURCES    = 4;
  localparam int unsigned DEF_AMOUNT_WIDTH = 16;

  localparam int unsigned AMOUNT_FIELDS = 4;
  localparam int unsigned FIELD_W       = 16;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 4;

  localparam int unsigned RST_NUM_PROCESSES = 8;
  localparam int unsigned RST_NUM_RESOURCES = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_PROCESSES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_RESOURCES = 2'd1;

  typedef enum logic [2:0] {
    KIND_LOAD_AVAIL = 3'd0,
    KIND_LOAD_MAX   = 3'd1,
    KIND_LOAD_ALLOC = 3'd2,
    KIND_REQUEST    = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_EXCEEDS_NEED  = 2'd1,
    ST_NOT_AVAILABLE = 2'd2,
    ST_UNSAFE        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WINIT,
    S_WALK,
    S_UNDO,
    S_EMIT,
    S_STREAM
  } state_t;

  typedef struct packed {
    logic fits;
    logic over_need;
    logic over_avail;
  } merge_t;

endpackage

@@ design/bsa_lane.sv @@
// One resource lane: need/work compare, request checks and work update.
// Depends on bsa_pkg.
module bsa_lane
  import bsa_pkg::*;
#(
  parameter int unsigned AW = DEF_AMOUNT_WIDTH,
  parameter int unsigned WW = DEF_AMOUNT_WIDTH + 4
) (
  input  logic                 active,
  input  logic signed [AW:0]   need,
  input  logic        [AW-1:0] alloc,
  input  logic        [AW-1:0] avail,
  input  logic        [AW-1:0] amt,
  input  logic        [WW-1:0] work,
  output logic                 fits,
  output logic                 over_need,
  output logic                 over_avail,
  output logic        [WW-1:0] work_sum
);

  logic signed [WW:0] need_x;
  logic signed [WW:0] work_x;

  assign need_x     = $signed({{(WW-AW){need[AW]}}, need});
  assign work_x     = $signed({1'b0, work});
  assign fits       = !active || (need_x <= work_x);
  assign over_need  = active && ($signed({1'b0, amt}) > need);
  assign over_avail = active && (amt > avail);
  assign work_sum   = work + WW'(alloc);

endmodule

@@ design/bsa_merge.sv @@
// Merge stage: combines the per-lane flags into one verdict.
// Depends on bsa_pkg.
module bsa_merge
  import bsa_pkg::*;
#(
  parameter int unsigned RESOURCES = DEF_RESOURCES
) (
  input  logic [RESOURCES-1:0] fits_vec,
  input  logic [RESOURCES-1:0] over_need_vec,
  input  logic [RESOURCES-1:0] over_avail_vec,
  output merge_t               flags
);

  assign flags.fits       = &fits_vec;
  assign flags.over_need  = |over_need_vec;
  assign flags.over_avail = |over_avail_vec;

endmodule

@@ design/bankers_safety_allocator_top.sv @@
// Top level of the banker's safety allocator: state tables, sequencer, output register.
// Depends on bsa_pkg, bsa_lane and bsa_merge.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the active process and
//   resource counts; write it only while the block is idle. cfg_ready is always high.
//   Input channel (in_valid/in_ready) takes one item when idle: loads, a request or a
//   safety query. Output channel (out_valid/out_ready) carries status, seq_process, last.
// Sequence:
//   Loads pass through S_EMIT to the output register. A request that fails the need or
//   availability check answers via S_EMIT; one that passes goes through S_WINIT, the
//   safety walk and, if unsafe, S_UNDO to S_EMIT; a query goes through S_WINIT and
//   the walk, then, if safe, gives one result per cycle per active process while the
//   output is not held. The walk inspects one process row per cycle over all resource
//   lanes, as there is one row read port. The next item is taken once the previous one
//   has handed its last result to the output register.
// Reset: all tables clear to zero, counts return to 8 processes and 4 resources.
// Stall: a held output keeps its result; one more item may be taken, then the sequencer
//   waits with its next result and the input stays not ready.
module bankers_safety_allocator_top
  import bsa_pkg::*;
#(
  parameter int unsigned PROCESSES    = DEF_PROCESSES,
  parameter int unsigned RESOURCES    = DEF_RESOURCES,
  parameter int unsigned AMOUNT_WIDTH = DEF_AMOUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             kind,
  input  logic [2:0]             process,
  input  logic [FIELD_W-1:0]     amount_0,
  input  logic [FIELD_W-1:0]     amount_1,
  input  logic [FIELD_W-1:0]     amount_2,
  input  logic [FIELD_W-1:0]     amount_3,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [2:0]             seq_process,
  output logic                   last
);

  localparam int unsigned AW = AMOUNT_WIDTH;
  localparam int unsigned PW = $clog2(PROCESSES);
  localparam int unsigned CW = $clog2(PROCESSES + 1);
  localparam int unsigned RW = $clog2(RESOURCES + 1);
  localparam int unsigned WW = AW + $clog2(PROCESSES) + 1;
  localparam int unsigned NP_RST =
    (RST_NUM_PROCESSES > PROCESSES) ? PROCESSES : RST_NUM_PROCESSES;
  localparam int unsigned NR_RST =
    (RST_NUM_RESOURCES > RESOURCES) ? RESOURCES : RST_NUM_RESOURCES;

  state_t state, state_next;

  logic [CW-1:0] np, np_cfg;
  logic [RW-1:0] nr, nr_cfg;
  logic [RESOURCES-1:0] res_act;

  logic [FIELD_W-1:0] amt_field [AMOUNT_FIELDS];
  logic [AW-1:0] amt_in [RESOURCES];
  logic in_fire, proc_ok_in, out_free;
  logic [PW-1:0] in_idx;

  logic [AW-1:0] avail [RESOURCES];
  logic [AW-1:0] max_row [PROCESSES][RESOURCES];
  logic [AW-1:0] alloc_row [PROCESSES][RESOURCES];
  logic signed [AW:0] need_row [PROCESSES][RESOURCES];

  logic [PW-1:0] rd_idx;
  logic [AW-1:0] max_rd [RESOURCES];
  logic [AW-1:0] alloc_rd [RESOURCES];
  logic signed [AW:0] need_rd [RESOURCES];

  logic [AW-1:0] req_amt [RESOURCES];
  logic [PW-1:0] req_idx;
  logic req_ok, is_query;

  logic [WW-1:0] work [RESOURCES];
  logic [WW-1:0] work_sum [RESOURCES];
  logic [PROCESSES-1:0] done;
  logic [PW-1:0] walk_idx, strm_idx;
  logic [CW-1:0] count, count_inc;
  logic progress, progress_now, grant, walk_last, all_done, strm_last;
  logic [PW-1:0] order [PROCESSES];

  logic [RESOURCES-1:0] lane_fits, lane_over_need, lane_over_avail;
  merge_t flags;

  status_t res_status, st_val, out_status;
  logic st_set, apply_req, undo_req, out_load, strm_adv, out_last;
  logic [2:0] out_seq;

  // configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    np_cfg = CW'(PROCESSES);
    if (cfg_data == '0) begin
      np_cfg = CW'(1);
    end else if (32'(cfg_data) <= PROCESSES) begin
      np_cfg = CW'(cfg_data);
    end
    nr_cfg = RW'(RESOURCES);
    if (cfg_data[2:0] == 3'd0) begin
      nr_cfg = RW'(1);
    end else if (32'(cfg_data[2:0]) <= RESOURCES) begin
      nr_cfg = RW'(cfg_data[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      np <= CW'(NP_RST);
      nr <= RW'(NR_RST);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NUM_PROCESSES) begin
        np <= np_cfg;
      end else if (cfg_index == REG_NUM_RESOURCES) begin
        nr <= nr_cfg;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      res_act[r] = (32'(r) < 32'(nr));
    end
  end

  // input side
  assign amt_field[0] = amount_0;
  assign amt_field[1] = amount_1;
  assign amt_field[2] = amount_2;
  assign amt_field[3] = amount_3;

  for (genvar g = 0; g < RESOURCES; g++) begin : g_amt
    if (g < AMOUNT_FIELDS) begin : g_field
      assign amt_in[g] = AW'(amt_field[g]);
    end else begin : g_zero
      assign amt_in[g] = '0;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign proc_ok_in = (32'(process) < PROCESSES);
  assign in_idx     = PW'(process);
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_amt  <= amt_in;
      req_idx  <= in_idx;
      req_ok   <= proc_ok_in;
      is_query <= (kind == KIND_QUERY);
    end
  end

  // single row read port
  always_comb begin
    unique case (state)
      S_WALK:  rd_idx = walk_idx;
      S_IDLE:  rd_idx = in_idx;
      default: rd_idx = req_idx;
    endcase
    for (int r = 0; r < RESOURCES; r++) begin
      max_rd[r]   = max_row[rd_idx][r];
      alloc_rd[r] = alloc_row[rd_idx][r];
      need_rd[r]  = need_row[rd_idx][r];
    end
  end

  // resource lanes and merge
  for (genvar g = 0; g < RESOURCES; g++) begin : g_lane
    bsa_lane #(
      .AW (AW),
      .WW (WW)
    ) u_lane (
      .active     (res_act[g]),
      .need       (need_rd[g]),
      .alloc      (alloc_rd[g]),
      .avail      (avail[g]),
      .amt        (req_amt[g]),
      .work       (work[g]),
      .fits       (lane_fits[g]),
      .over_need  (lane_over_need[g]),
      .over_avail (lane_over_avail[g]),
      .work_sum   (work_sum[g])
    );
  end

  bsa_merge #(
    .RESOURCES (RESOURCES)
  ) u_merge (
    .fits_vec       (lane_fits),
    .over_need_vec  (lane_over_need),
    .over_avail_vec (lane_over_avail),
    .flags          (flags)
  );

  // walk step
  assign grant        = !done[walk_idx] && flags.fits;
  assign count_inc    = count + CW'(grant);
  assign walk_last    = (CW'(walk_idx) == np - CW'(1));
  assign all_done     = (count_inc == np);
  assign progress_now = progress || grant;
  assign strm_last    = (CW'(strm_idx) == np - CW'(1));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    st_set     = 1'b0;
    st_val     = ST_OK;
    apply_req  = 1'b0;
    undo_req   = 1'b0;
    out_load   = 1'b0;
    out_status = ST_OK;
    out_seq    = 3'd0;
    out_last   = 1'b1;
    strm_adv   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (kind)
            KIND_LOAD_AVAIL, KIND_LOAD_MAX, KIND_LOAD_ALLOC: begin
              st_set     = 1'b1;
              st_val     = ST_OK;
              state_next = S_EMIT;
            end
            KIND_REQUEST: state_next = S_CHECK;
            KIND_QUERY:   state_next = S_WINIT;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        state_next = S_EMIT;
        st_set     = 1'b1;
        priority if (!req_ok) begin
          st_val = ST_UNSAFE;
        end else if (flags.over_need) begin
          st_val = ST_EXCEEDS_NEED;
        end else if (flags.over_avail) begin
          st_val = ST_NOT_AVAILABLE;
        end else begin
          st_set     = 1'b0;
          apply_req  = 1'b1;
          state_next = S_WINIT;
        end
      end
      S_WINIT: state_next = S_WALK;
      S_WALK: begin
        if (all_done) begin
          if (is_query) begin
            state_next = S_STREAM;
          end else begin
            st_set     = 1'b1;
            st_val     = ST_OK;
            state_next = S_EMIT;
          end
        end else if (walk_last && !progress_now) begin
          st_set     = 1'b1;
          st_val     = ST_UNSAFE;
          state_next = is_query ? S_EMIT : S_UNDO;
        end
      end
      S_UNDO: begin
        undo_req   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = res_status;
          state_next = S_IDLE;
        end
      end
      S_STREAM: begin
        if (out_free) begin
          out_load = 1'b1;
          out_seq  = 3'(order[strm_idx]);
          out_last = strm_last;
          strm_adv = 1'b1;
          if (strm_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_set) begin
      res_status <= st_val;
    end
  end

  // state tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RESOURCES; r++) begin
        avail[r] <= '0;
      end
      for (int p = 0; p < PROCESSES; p++) begin
        for (int r = 0; r < RESOURCES; r++) begin
          max_row[p][r]   <= '0;
          alloc_row[p][r] <= '0;
          need_row[p][r]  <= '0;
        end
      end
    end else begin
      if (in_fire && (kind == KIND_LOAD_AVAIL)) begin
        for (int r = 0; r < RESOURCES; r++) begin
          avail[r] <= amt_in[r];
        end
      end
      if (in_fire && (kind == KIND_LOAD_MAX) && proc_ok_in) begin
        for (int r = 0; r < RESOURCES; r++) begin
          max_row[in_idx][r]  <= amt_in[r];
          need_row[in_idx][r] <= $signed({1'b0, amt_in[r]}) - $signed({1'b0, alloc_rd[r]});
        end
      end
      if (in_fire && (kind == KIND_LOAD_ALLOC) && proc_ok_in) begin
        for (int r = 0; r < RESOURCES; r++) begin
          alloc_row[in_idx][r] <= amt_in[r];
          need_row[in_idx][r]  <= $signed({1'b0, max_rd[r]}) - $signed({1'b0, amt_in[r]});
        end
      end
      if (apply_req) begin
        for (int r = 0; r < RESOURCES; r++) begin
          if (res_act[r]) begin
            avail[r]              <= avail[r] - req_amt[r];
            alloc_row[req_idx][r] <= alloc_rd[r] + req_amt[r];
            need_row[req_idx][r]  <= need_rd[r] - $signed({1'b0, req_amt[r]});
          end
        end
      end
      if (undo_req) begin
        for (int r = 0; r < RESOURCES; r++) begin
          if (res_act[r]) begin
            avail[r]              <= avail[r] + req_amt[r];
            alloc_row[req_idx][r] <= alloc_rd[r] - req_amt[r];
            need_row[req_idx][r]  <= need_rd[r] + $signed({1'b0, req_amt[r]});
          end
        end
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (state == S_WINIT) begin
      for (int r = 0; r < RESOURCES; r++) begin
        work[r] <= WW'(avail[r]);
      end
      done     <= '0;
      walk_idx <= '0;
      count    <= '0;
      progress <= 1'b0;
      strm_idx <= '0;
    end else if (state == S_WALK) begin
      if (grant) begin
        work                     <= work_sum;
        done[walk_idx]           <= 1'b1;
        order[count[PW-1:0]]     <= walk_idx;
      end
      count    <= count_inc;
      progress <= walk_last ? 1'b0 : progress_now;
      walk_idx <= walk_last ? '0 : walk_idx + PW'(1);
    end else if (strm_adv) begin
      strm_idx <= strm_idx + PW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= out_status;
      seq_process <= out_seq;
      last        <= out_last;
    end
  end

  // checks
  a_seq_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || seq_process == 3'd0))
    else $error("sequence index on a non-ok result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (count < np))
    else $error("walk grant count reached active count inside walk");

  a_undo_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNDO) |-> ($past(state) == S_WALK && !is_query))
    else $error("rollback without a failed request walk");

  a_emit_has_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM && out_load) |-> (out_status == ST_OK))
    else $error("streamed result with non-ok status");

endmodule
